FILE: design/khte_pkg.sv
// Shared types and constants for the keyframe Hermite track evaluator.
package khte_pkg;

  // Data memory geometry and fixed-point format.
  localparam int MEM_AW    = 10;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam int FRAC_BITS = 16;

  // Sequencer step counts.
  localparam int CNT_W     = 5;
  localparam int LOAD_LAST = 5;
  localparam int DIV_LAST  = FRAC_BITS - 1;
  localparam int MUL_LAST  = 8;

  // Register file address width.
  localparam int REG_AW = 5;

  typedef enum logic [2:0] {
    REG_TRACK_START   = 3'd0,
    REG_KEY_COUNT     = 3'd1,
    REG_TANGENT_MODE  = 3'd2,
    REG_DEFAULT_VALUE = 3'd3,
    REG_DATA_COUNT    = 3'd4
  } khte_reg_e;

  typedef struct packed {
    logic [9:0]         track_start;
    logic [9:0]         key_count;
    logic               tangent_mode;
    logic signed [31:0] default_value;
    logic [10:0]        data_count;
  } khte_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_SINGLE, ST_FIRST, ST_LAST, ST_VAL, ST_SRCH,
    ST_SCMP, ST_LOAD, ST_DIVI, ST_DIV, ST_MUL, ST_FIN
  } khte_state_e;

  typedef enum logic [3:0] {
    OP_IDLE, OP_CHECK, OP_SINGLE, OP_FIRST, OP_LAST, OP_VAL, OP_SRCH,
    OP_SCMP, OP_LOAD, OP_DIVI, OP_DIV, OP_MUL, OP_FIN
  } khte_op_e;

  typedef struct packed {
    khte_op_e         op;
    logic [CNT_W-1:0] cnt;
    logic             wr_en;
    logic             eval_start;
  } khte_cmd_t;

  typedef struct packed {
    logic dflt;
    logic key_one;
    logic le_first;
    logic ge_frame;
    logic span_gt1;
    logic len_bad;
    logic out_free;
  } khte_sts_t;

endpackage

FILE: design/keyframe_hermite_track_eval_unit.sv
// Top level of the keyframe Hermite track evaluator: register file, sequencer and datapath.
// A write item stores one word into the 1024-word key memory and is taken in any idle
// cycle with no result. An evaluate item returns one result. A default answer passes only
// the check and finish steps; a single key adds its own step, an answer clamped to the
// first key adds the first-key test and a value step, one clamped to the last key also a
// last-key test. An interpolated answer runs a binary search of p probes, where p is at
// most ceil(log2(key_count - 1)), each probe one registered memory read and its compare,
// then six key word reads, a 16-step restoring divider for the segment parameter and
// nine steps on one shared multiplier. A segment of zero or negative length ends after
// the key loads. Input is taken only while no evaluation is in progress, so the next
// item can enter in the cycle after the result is registered. A finished result sits in
// an output register while the next item enters; an evaluation whose result finds that
// register still full waits in its finish step.
module keyframe_hermite_track_eval_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [9:0]         word_addr_i,
  input  logic signed [31:0] word_value_i,
  input  logic signed [31:0] query_frame_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] track_value_o,
  output logic               used_default_o
);
  import khte_pkg::*;

  khte_cfg_t cfg_q;
  khte_cmd_t cmd;
  khte_sts_t sts;
  khte_reg_e reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = khte_reg_e'(paddr[REG_AW-1:2]);

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_TRACK_START:   cfg_q.track_start   <= pwdata[9:0];
        REG_KEY_COUNT:     cfg_q.key_count     <= pwdata[9:0];
        REG_TANGENT_MODE:  cfg_q.tangent_mode  <= pwdata[0];
        REG_DEFAULT_VALUE: cfg_q.default_value <= pwdata;
        REG_DATA_COUNT:    cfg_q.data_count    <= pwdata[10:0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_sel)
      REG_TRACK_START:   prdata = {22'd0, cfg_q.track_start};
      REG_KEY_COUNT:     prdata = {22'd0, cfg_q.key_count};
      REG_TANGENT_MODE:  prdata = {31'd0, cfg_q.tangent_mode};
      REG_DEFAULT_VALUE: prdata = cfg_q.default_value;
      REG_DATA_COUNT:    prdata = {21'd0, cfg_q.data_count};
      default:           prdata = 32'd0;
    endcase
  end

  khte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  khte_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .word_addr_i    (word_addr_i),
    .word_value_i   (word_value_i),
    .query_frame_i  (query_frame_i),
    .out_ready_i    (out_ready_i),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .track_value_o  (track_value_o),
    .used_default_o (used_default_o)
  );

  // A result appears only after the sequencer finishes an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.op == OP_FIN))
    else $error("result raised outside the finish step");

  // The multiplier schedule never runs past its last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_MUL) |-> (cmd.cnt <= CNT_W'(MUL_LAST)))
    else $error("multiply step counter out of range");

  // A write item never starts an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !action_i) |=> (cmd.op == OP_IDLE))
    else $error("write item left the idle state");

endmodule

FILE: design/khte_ctrl.sv
// Sequencer state machine for the keyframe Hermite track evaluator.
module khte_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               action_i,
  input  khte_pkg::khte_sts_t sts_i,
  output logic               in_ready_o,
  output khte_pkg::khte_cmd_t cmd_o
);
  import khte_pkg::*;

  khte_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Next state and step counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && action_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.dflt) state_d = ST_FIN;
        else if (sts_i.key_one) state_d = ST_SINGLE;
        else state_d = ST_FIRST;
      end
      ST_SINGLE: state_d = ST_FIN;
      ST_FIRST: begin
        state_d = sts_i.le_first ? ST_VAL : ST_LAST;
      end
      ST_LAST: begin
        state_d = sts_i.ge_frame ? ST_VAL : ST_SRCH;
      end
      ST_VAL: state_d = ST_FIN;
      ST_SRCH: begin
        cnt_d = '0;
        state_d = sts_i.span_gt1 ? ST_SCMP : ST_LOAD;
      end
      ST_SCMP: state_d = ST_SRCH;
      ST_LOAD: begin
        if (cnt_q == CNT_W'(LOAD_LAST)) begin
          state_d = ST_DIVI;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIVI: begin
        cnt_d = '0;
        state_d = sts_i.len_bad ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(DIV_LAST)) begin
          cnt_d = '0;
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(MUL_LAST)) state_d = ST_FIN;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_FIN: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o.cnt        = cnt_q;
    cmd_o.wr_en      = (state_q == ST_IDLE) && in_valid_i && !action_i;
    cmd_o.eval_start = (state_q == ST_IDLE) && in_valid_i && action_i;
    case (state_q)
      ST_IDLE:   cmd_o.op = OP_IDLE;
      ST_CHECK:  cmd_o.op = OP_CHECK;
      ST_SINGLE: cmd_o.op = OP_SINGLE;
      ST_FIRST:  cmd_o.op = OP_FIRST;
      ST_LAST:   cmd_o.op = OP_LAST;
      ST_VAL:    cmd_o.op = OP_VAL;
      ST_SRCH:   cmd_o.op = OP_SRCH;
      ST_SCMP:   cmd_o.op = OP_SCMP;
      ST_LOAD:   cmd_o.op = OP_LOAD;
      ST_DIVI:   cmd_o.op = OP_DIVI;
      ST_DIV:    cmd_o.op = OP_DIV;
      ST_MUL:    cmd_o.op = OP_MUL;
      ST_FIN:    cmd_o.op = OP_FIN;
      default:   cmd_o.op = OP_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: design/khte_dp.sv
// Datapath: key memory, search registers, divider, shared multiplier, result register.
module khte_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  khte_pkg::khte_cfg_t cfg_i,
  input  khte_pkg::khte_cmd_t cmd_i,
  input  logic [9:0]          word_addr_i,
  input  logic signed [31:0]  word_value_i,
  input  logic signed [31:0]  query_frame_i,
  input  logic                out_ready_i,
  output khte_pkg::khte_sts_t sts_o,
  output logic                out_valid_o,
  output logic signed [31:0]  track_value_o,
  output logic                used_default_o
);
  import khte_pkg::*;

  localparam int HW    = FRAC_BITS + 3;
  localparam int ACC_W = 52;
  localparam int MW    = 34;

  function automatic logic [11:0] times_stride(input logic [9:0] idx, input logic mode);
    logic [11:0] r;
    if (mode) r = {idx, 2'b00};
    else r = {1'b0, idx, 1'b0} + {2'b00, idx};
    return r;
  endfunction

  logic [31:0]        mem [MEM_DEPTH];
  logic signed [31:0] rd_q;
  logic [MEM_AW-1:0]  rd_addr;

  logic signed [31:0] frame_q;
  logic [9:0]         lo_q, hi_q;
  logic signed [31:0] slot_q [6];
  logic [32:0]        len_q, rem_q;
  logic [FRAC_BITS-1:0] quo_q, u2_q, u3_q;
  logic signed [HW-1:0] h00_q, h10_q, h01_q, h11_q;
  logic signed [MW-1:0] s10_q, s11_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [31:0] res_q;
  logic               rdef_q;

  // Track bounds check.
  logic [9:0]  last_idx, mid_idx;
  logic [10:0] mid_sum;
  logic [12:0] track_end;
  logic        dflt;
  assign last_idx  = cfg_i.key_count - 10'd1;
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_idx   = mid_sum[10:1];
  assign track_end = {3'b000, cfg_i.track_start}
                   + {1'b0, times_stride(cfg_i.key_count, cfg_i.tangent_mode)};
  always_comb begin
    if (cfg_i.key_count == 10'd0) dflt = 1'b1;
    else if (cfg_i.key_count == 10'd1) dflt = {1'b0, cfg_i.track_start} >= cfg_i.data_count;
    else dflt = track_end > {2'b00, cfg_i.data_count};
  end

  // Segment length and offset into the segment.
  logic signed [32:0] len_s, diff_s;
  assign len_s  = {slot_q[3][31], slot_q[3]} - {slot_q[0][31], slot_q[0]};
  assign diff_s = {frame_q[31], frame_q} - {slot_q[0][31], slot_q[0]};

  logic span_gt1, le_first, ge_frame;
  assign span_gt1 = (hi_q - lo_q) > 10'd1;
  assign le_first = frame_q <= rd_q;
  assign ge_frame = frame_q >= rd_q;

  always_comb begin
    sts_o.dflt     = dflt;
    sts_o.key_one  = (cfg_i.key_count == 10'd1);
    sts_o.le_first = le_first;
    sts_o.ge_frame = ge_frame;
    sts_o.span_gt1 = span_gt1;
    sts_o.len_bad  = (len_s <= 33'sd0) || diff_s[32];
    sts_o.out_free = !out_valid_o || out_ready_i;
  end

  // Read address: key index times stride plus word offset.
  logic [9:0]  rd_idx;
  logic [1:0]  rd_off;
  logic [2:0]  item;
  logic [12:0] addr_full;
  always_comb begin
    rd_idx = 10'd0;
    rd_off = 2'd0;
    item   = cmd_i.cnt[2:0] + 3'd1;
    case (cmd_i.op)
      OP_FIRST: begin
        if (le_first) rd_off = 2'd1;
        else rd_idx = last_idx;
      end
      OP_LAST: begin
        rd_idx = last_idx;
        rd_off = 2'd1;
      end
      OP_SRCH: rd_idx = span_gt1 ? mid_idx : lo_q;
      OP_LOAD: begin
        rd_idx = (item < 3'd3) ? lo_q : hi_q;
        case (item)
          3'd1:    rd_off = 2'd1;
          3'd2:    rd_off = cfg_i.tangent_mode ? 2'd3 : 2'd2;
          3'd4:    rd_off = 2'd1;
          3'd5:    rd_off = 2'd2;
          default: rd_off = 2'd0;
        endcase
      end
      default: rd_idx = 10'd0;
    endcase
    addr_full = {3'b000, cfg_i.track_start}
              + {1'b0, times_stride(rd_idx, cfg_i.tangent_mode)} + {11'd0, rd_off};
    rd_addr = addr_full[MEM_AW-1:0];
  end

  // Key memory: one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[word_addr_i[MEM_AW-1:0]] <= word_value_i;
    rd_q <= mem[rd_addr];
  end

  // Divider step.
  logic [33:0] rem2;
  logic        div_ge;
  assign rem2   = {rem_q, 1'b0};
  assign div_ge = rem2 >= {1'b0, len_q};

  // Shared multiplier and its operand selection.
  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] prod, psh;
  logic signed [ACC_W-1:0] acc_sum;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.cnt)
      CNT_W'(0): begin
        ma = MW'(signed'({1'b0, quo_q}));
        mb = MW'(signed'({1'b0, quo_q}));
      end
      CNT_W'(1): begin
        ma = MW'(signed'({1'b0, u2_q}));
        mb = MW'(signed'({1'b0, quo_q}));
      end
      CNT_W'(3): begin
        ma = MW'(h10_q);
        mb = MW'(signed'({1'b0, len_q}));
      end
      CNT_W'(4): begin
        ma = MW'(h11_q);
        mb = MW'(signed'({1'b0, len_q}));
      end
      CNT_W'(5): begin
        ma = MW'(h00_q);
        mb = MW'(slot_q[1]);
      end
      CNT_W'(6): begin
        ma = MW'(h01_q);
        mb = MW'(slot_q[4]);
      end
      CNT_W'(7): begin
        ma = s10_q;
        mb = MW'(slot_q[2]);
      end
      CNT_W'(8): begin
        ma = s11_q;
        mb = MW'(slot_q[5]);
      end
      default: ma = '0;
    endcase
    prod    = ma * mb;
    psh     = prod >>> FRAC_BITS;
    acc_sum = acc_q + psh[ACC_W-1:0];
  end

  // Hermite weights from u, u^2 and u^3.
  logic signed [HW-1:0] u_w, u2_w, u3_w, one_w;
  assign u_w   = HW'(signed'({1'b0, quo_q}));
  assign u2_w  = HW'(signed'({1'b0, u2_q}));
  assign u3_w  = HW'(signed'({1'b0, u3_q}));
  assign one_w = HW'(1) <<< FRAC_BITS;

  // Tangent scale clamp.
  function automatic logic signed [MW-1:0] clamp_s(input logic signed [2*MW-1:0] x);
    logic signed [2*MW-1:0] lim;
    lim = (2*MW)'(1) <<< 31;
    if (x > lim) return MW'(lim);
    if (x < -lim) return MW'(-lim);
    return x[MW-1:0];
  endfunction

  // Final saturation to the 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (x < ACC_W'(-64'sh8000_0000)) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      frame_q <= query_frame_i;
      rdef_q  <= 1'b0;
    end
    case (cmd_i.op)
      OP_CHECK: begin
        res_q  <= cfg_i.default_value;
        rdef_q <= dflt;
      end
      OP_SINGLE, OP_VAL: res_q <= rd_q;
      OP_FIRST: if (le_first) res_q <= res_q;
      OP_LAST: begin
        lo_q <= 10'd0;
        hi_q <= last_idx;
      end
      OP_SCMP: begin
        if (ge_frame) lo_q <= mid_idx;
        else hi_q <= mid_idx;
      end
      OP_LOAD: slot_q[cmd_i.cnt[2:0]] <= rd_q;
      OP_DIVI: begin
        len_q <= len_s;
        rem_q <= diff_s;
        quo_q <= '0;
        res_q <= slot_q[1];
      end
      OP_DIV: begin
        rem_q <= div_ge ? 33'(rem2 - {1'b0, len_q}) : rem2[32:0];
        quo_q <= {quo_q[FRAC_BITS-2:0], div_ge};
      end
      OP_MUL: begin
        case (cmd_i.cnt)
          CNT_W'(0): u2_q <= psh[FRAC_BITS-1:0];
          CNT_W'(1): u3_q <= psh[FRAC_BITS-1:0];
          CNT_W'(2): begin
            h00_q <= (u3_w <<< 1) - (u2_w + (u2_w <<< 1)) + one_w;
            h10_q <= u3_w - (u2_w <<< 1) + u_w;
            h01_q <= (u2_w + (u2_w <<< 1)) - (u3_w <<< 1);
            h11_q <= u3_w - u2_w;
          end
          CNT_W'(3): s10_q <= clamp_s(psh);
          CNT_W'(4): s11_q <= clamp_s(psh);
          CNT_W'(5): acc_q <= psh[ACC_W-1:0];
          CNT_W'(6), CNT_W'(7): acc_q <= acc_sum;
          CNT_W'(8): res_q <= sat32(acc_sum);
          default: acc_q <= acc_q;
        endcase
      end
      default: res_q <= res_q;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.op == OP_FIN && sts_o.out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FIN && sts_o.out_free) begin
      track_value_o  <= res_q;
      used_default_o <= rdef_q;
    end
  end

endmodule
